// ===== src/tlpw_pkg.sv =====
// Shared types and constants for the two-level page walk.
// Used by the controller, the datapath and the top level; no dependencies.

package tlpw_pkg;

   // Field geometry of a 10/10/12 walk
   localparam int FRAME_BITS   = 20;
   localparam int INDEX_BITS   = 10;
   localparam int OFFSET_BITS  = 12;
   localparam int DIR_IDX_LSB  = 22;
   localparam int TAB_IDX_LSB  = 12;
   localparam int PRESENT_POS  = 20;
   localparam int VA_KEEP_BITS = 22;

   // Result status codes
   typedef logic [2:0] status_type;
   localparam status_type ST_OK            = 3'd0;
   localparam status_type ST_BAD_DIR_FRAME = 3'd1;
   localparam status_type ST_DIR_ABSENT    = 3'd2;
   localparam status_type ST_BAD_TAB_FRAME = 3'd3;
   localparam status_type ST_TAB_ABSENT    = 3'd4;
   localparam status_type ST_WRITE_DONE    = 3'd5;

   // Source of the result loaded into the output register
   typedef enum logic [1:0] {
      SEL_DIR = 2'd0,
      SEL_TAB = 2'd1,
      SEL_FIN = 2'd2
   } out_sel_type;

   // Controller to datapath
   typedef struct packed {
      logic        clear_en;
      logic        accept;
      logic        tab_rd;
      logic        load_out;
      out_sel_type out_sel;
   } cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic clear_last;
      logic fin_now;
      logic dir_stop;
   } stat_type;

endpackage

// ===== src/tlpw_channels.sv =====
// Handshake channel interfaces for the page walk request and response.
// Standalone; no package dependency.

interface tlpw_req_if;
   logic        valid;
   logic        ready;
   logic        op;
   logic [31:0] vaddr;
   logic [7:0]  write_frame;
   logic [9:0]  write_index;
   logic [31:0] write_entry;

   modport source (
      output valid, op, vaddr, write_frame, write_index, write_entry,
      input  ready
   );
   modport sink (
      input  valid, op, vaddr, write_frame, write_index, write_entry,
      output ready
   );
endinterface

interface tlpw_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] paddr;
   logic [2:0]  status;

   modport source (
      output valid, paddr, status,
      input  ready
   );
   modport sink (
      input  valid, paddr, status,
      output ready
   );
endinterface

// ===== src/two_level_page_walk.sv =====
// Top level of the two-level (10/10/12) page-table walk.
// Depends on tlpw_pkg, tlpw_channels, tlpw_ctrl and tlpw_datapath.
//
//   channel   | dir | handshake     | beat contents
//   ----------+-----+---------------+------------------------------------------
//   req_ch    | in  | valid/ready   | op, vaddr, write_frame/index/entry
//   rsp_ch    | out | valid/ready   | paddr, status
//   csr_*     | in  | csr_wr_en     | csr_wr_data = directory_base_frame
//
// A translation steps through accept, directory read and table read, since the
// two reads of the one-port-read table store depend on each other; a write or an
// out-of-range directory frame skips both reads, and a directory fault skips the
// table read. After reset the store is swept to zero, one word a cycle, over all
// FRAME_COUNT*1024 words; req_ch.ready stays low during the sweep. A held
// response stalls the walk only at its last step; one request is in flight.

module two_level_page_walk import tlpw_pkg::*; #(
   parameter int FRAME_COUNT = 256
) (
   input  logic              clock,
   input  logic              reset,
   tlpw_req_if.sink          req_ch,
   tlpw_rsp_if.source        rsp_ch,
   input  logic              csr_wr_en,
   input  logic [19:0]       csr_wr_data
);

   cmd_type  cmd;
   stat_type stat;

   tlpw_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .stat      (stat),
      .cmd       (cmd),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .rsp_valid (rsp_ch.valid),
      .rsp_ready (rsp_ch.ready)
   );

   tlpw_datapath #(
      .FRAME_COUNT (FRAME_COUNT)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .stat            (stat),
      .req_op          (req_ch.op),
      .req_vaddr       (req_ch.vaddr),
      .req_write_frame (req_ch.write_frame),
      .req_write_index (req_ch.write_index),
      .req_write_entry (req_ch.write_entry),
      .csr_wr_en       (csr_wr_en),
      .csr_wr_data     (csr_wr_data),
      .rsp_paddr       (rsp_ch.paddr),
      .rsp_status      (rsp_ch.status)
   );

endmodule

// ===== src/tlpw_ram.sv =====
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.

module tlpw_ram #(
   parameter int WIDTH  = 32,
   parameter int DEPTH  = 1024,
   parameter int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write one word, read one word; read data holds while rd_en is low
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== src/tlpw_datapath.sv =====
// Datapath of the page walk: table store, clear counter, base register,
// entry checks and the output register. Depends on tlpw_pkg and tlpw_ram.

module tlpw_datapath import tlpw_pkg::*; #(
   parameter int FRAME_COUNT = 256
) (
   input  logic        clock,
   input  logic        reset,
   input  cmd_type     cmd,
   output stat_type    stat,
   input  logic        req_op,
   input  logic [31:0] req_vaddr,
   input  logic [7:0]  req_write_frame,
   input  logic [9:0]  req_write_index,
   input  logic [31:0] req_write_entry,
   input  logic        csr_wr_en,
   input  logic [19:0] csr_wr_data,
   output logic [31:0] rsp_paddr,
   output logic [2:0]  rsp_status
);

   localparam int FW    = $clog2(FRAME_COUNT);
   localparam int AW    = FW + INDEX_BITS;
   localparam int DEPTH = FRAME_COUNT * (2 ** INDEX_BITS);
   localparam logic [FRAME_BITS:0] FRAME_LIMIT = (FRAME_BITS + 1)'(FRAME_COUNT);
   localparam logic [AW-1:0]       CLEAR_LAST  = AW'(DEPTH - 1);

   logic [FRAME_BITS-1:0]   base_ff;
   logic [AW-1:0]           clr_cnt_ff;
   logic [AW-1:0]           clr_cnt_in;
   logic [VA_KEEP_BITS-1:0] item_va_ff;
   status_type              fin_status_ff;
   status_type              fin_status_in;
   logic [31:0]             phys_ff;
   status_type              status_ff;
   logic [31:0]             phys_in;
   status_type              status_in;

   logic                    ram_wr_en;
   logic [AW-1:0]           ram_wr_addr;
   logic [31:0]             ram_wr_data;
   logic                    ram_rd_en;
   logic [AW-1:0]           ram_rd_addr;
   logic [31:0]             ram_rd_data;

   logic [FRAME_BITS-1:0]   wframe_ext;
   logic                    base_ok;
   logic                    wr_ok;
   logic                    is_walk;
   logic                    ent_present;
   logic [FRAME_BITS-1:0]   ent_frame;
   logic                    tab_ok;
   status_type              dir_status;

   // Range checks on frame numbers
   assign wframe_ext  = FRAME_BITS'(req_write_frame);
   assign base_ok     = {1'b0, base_ff} < FRAME_LIMIT;
   assign wr_ok       = {1'b0, wframe_ext} < FRAME_LIMIT;
   assign is_walk     = req_op;

   // Decode the entry coming out of the store
   assign ent_present = ram_rd_data[PRESENT_POS];
   assign ent_frame   = ram_rd_data[FRAME_BITS-1:0];
   assign tab_ok      = {1'b0, ent_frame} < FRAME_LIMIT;

   always_comb begin
      if (!ent_present) begin
         dir_status = ST_DIR_ABSENT;
      end else if (!tab_ok) begin
         dir_status = ST_BAD_TAB_FRAME;
      end else begin
         dir_status = ST_OK;
      end
   end

   assign stat.clear_last = (clr_cnt_ff == CLEAR_LAST);
   assign stat.fin_now    = !is_walk || !base_ok;
   assign stat.dir_stop   = !ent_present || !tab_ok;

   // Store port muxing: clear sweep, entry write, directory and table reads
   assign ram_wr_en   = cmd.clear_en || (cmd.accept && !is_walk && wr_ok);
   assign ram_wr_addr = cmd.clear_en ? clr_cnt_ff
                                     : {wframe_ext[FW-1:0], req_write_index};
   assign ram_wr_data = cmd.clear_en ? '0 : req_write_entry;
   assign ram_rd_en   = (cmd.accept && is_walk && base_ok) || cmd.tab_rd;
   assign ram_rd_addr = cmd.accept
      ? {base_ff[FW-1:0], req_vaddr[DIR_IDX_LSB +: INDEX_BITS]}
      : {ent_frame[FW-1:0], item_va_ff[TAB_IDX_LSB +: INDEX_BITS]};

   tlpw_ram #(
      .WIDTH (32),
      .DEPTH (DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // Advance the clear sweep
   assign clr_cnt_in = cmd.clear_en ? clr_cnt_ff + AW'(1) : clr_cnt_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_cnt_ff <= '0;
         base_ff    <= '0;
      end else begin
         clr_cnt_ff <= clr_cnt_in;
         if (csr_wr_en) begin
            base_ff <= csr_wr_data;
         end
      end
   end

   // Hold the accepted item and any status settled at accept
   assign fin_status_in = is_walk ? ST_BAD_DIR_FRAME : ST_WRITE_DONE;

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         item_va_ff    <= req_vaddr[VA_KEEP_BITS-1:0];
         fin_status_ff <= fin_status_in;
      end
   end

   // Select the result for the output register
   always_comb begin
      phys_in   = '0;
      status_in = fin_status_ff;
      case (cmd.out_sel)
         SEL_DIR: begin
            status_in = dir_status;
         end
         SEL_TAB: begin
            if (ent_present) begin
               status_in = ST_OK;
               phys_in   = {ent_frame, item_va_ff[OFFSET_BITS-1:0]};
            end else begin
               status_in = ST_TAB_ABSENT;
            end
         end
         default: begin
            status_in = fin_status_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.load_out) begin
         phys_ff   <= phys_in;
         status_ff <= status_in;
      end
   end

   assign rsp_paddr  = phys_ff;
   assign rsp_status = status_ff;

endmodule

// ===== src/tlpw_ctrl.sv =====
// Controller of the page walk: clear sweep, walk sequencing, result valid.
// Depends on tlpw_pkg.

module tlpw_ctrl import tlpw_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  stat_type stat,
   output cmd_type  cmd,
   input  logic     req_valid,
   output logic     req_ready,
   output logic     rsp_valid,
   input  logic     rsp_ready
);

   typedef enum logic [4:0] {
      S_CLEAR = 5'b00001,
      S_IDLE  = 5'b00010,
      S_DIR   = 5'b00100,
      S_TAB   = 5'b01000,
      S_FIN   = 5'b10000
   } state_type;

   state_type state_ff;
   state_type state_in;
   logic      rsp_valid_ff;
   logic      rsp_valid_in;
   logic      out_free;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == S_IDLE);

   // Sequence the walk
   always_comb begin
      state_in     = state_ff;
      cmd.clear_en = 1'b0;
      cmd.accept   = 1'b0;
      cmd.tab_rd   = 1'b0;
      cmd.load_out = 1'b0;
      cmd.out_sel  = SEL_FIN;
      unique case (state_ff)
         S_CLEAR: begin
            cmd.clear_en = 1'b1;
            if (stat.clear_last) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_valid) begin
               cmd.accept = 1'b1;
               state_in   = stat.fin_now ? S_FIN : S_DIR;
            end
         end
         S_DIR: begin
            cmd.out_sel = SEL_DIR;
            if (!stat.dir_stop) begin
               cmd.tab_rd = 1'b1;
               state_in   = S_TAB;
            end else if (out_free) begin
               cmd.load_out = 1'b1;
               state_in     = S_IDLE;
            end
         end
         S_TAB: begin
            cmd.out_sel = SEL_TAB;
            if (out_free) begin
               cmd.load_out = 1'b1;
               state_in     = S_IDLE;
            end
         end
         S_FIN: begin
            cmd.out_sel = SEL_FIN;
            if (out_free) begin
               cmd.load_out = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_CLEAR;
         end
      endcase
   end

   // Set on load, drop when the beat is taken
   always_comb begin
      if (cmd.load_out) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

// ===== dv/two_level_page_walk_tb.sv =====
// Self-checking testbench for the two-level (10/10/12) page-table walk.
// Depends on tlpw_pkg, the tlpw_req_if/tlpw_rsp_if interfaces and the RTL below them.
`timescale 1ns / 1ps

module two_level_page_walk_tb import tlpw_pkg::*; ();

   localparam int FRAME_COUNT     = 256;
   localparam int STORE_WORDS     = FRAME_COUNT * 1024;
   localparam int CLOCK_HALF      = 6;
   localparam int RESET_CYCLES    = 9;
   localparam int DRAIN_CYCLES    = 8;
   localparam int HOLD_OFF_CYCLES = 240;
   localparam int PHASE_COUNT     = 6;
   // Sweep of the store after reset, plus a slow run of ~750 items, taken 4x over
   localparam int CYCLE_LIMIT     = 1_200_000;
   localparam int MAX_PRINTED     = 40;

   localparam bit OP_WRITE     = 1'b0;
   localparam bit OP_TRANSLATE = 1'b1;

   localparam logic [31:0] ENTRY_PRESENT = 32'h1 << PRESENT_POS;

   typedef struct {
      logic [31:0] paddr;
      status_type  status;
   } walk_result_type;

   // Mirror of the page-table store and the directory base; computes each walk
   class walk_mirror;
      logic [31:0]     page_words [STORE_WORDS];
      logic [19:0]     dir_base;
      walk_result_type pending_walks [$];
      int              status_count [6];
      int              mismatch_count;
      int              translations;
      int              writes;
      int              base_settings;

      function new();
         foreach (page_words[i]) page_words[i] = '0;
         foreach (status_count[i]) status_count[i] = 0;
         dir_base       = '0;
         mismatch_count = 0;
         translations   = 0;
         writes         = 0;
         base_settings  = 0;
      endfunction

      function void set_base(logic [19:0] base);
         dir_base = base;
         base_settings++;
      endfunction

      function int pending();
         return pending_walks.size();
      endfunction

      // Walk the mirror for one accepted request beat and queue its outcome
      function void note_request(bit op, logic [31:0] va, logic [7:0] wf,
                                 logic [9:0] wi, logic [31:0] we);
         walk_result_type res;
         logic [31:0]     dte;
         logic [31:0]     pte;
         int unsigned     tframe;
         res.paddr = '0;
         if (op == OP_WRITE) begin
            writes++;
            if (int'(wf) < FRAME_COUNT) page_words[int'(wf) * 1024 + int'(wi)] = we;
            res.status = ST_WRITE_DONE;
         end else begin
            translations++;
            if (int'(dir_base) >= FRAME_COUNT) begin
               res.status = ST_BAD_DIR_FRAME;
            end else begin
               dte = page_words[int'(dir_base) * 1024 + int'(va[31:DIR_IDX_LSB])];
               tframe = 32'(dte[FRAME_BITS-1:0]);
               if (!dte[PRESENT_POS]) begin
                  res.status = ST_DIR_ABSENT;
               end else if (tframe >= FRAME_COUNT) begin
                  res.status = ST_BAD_TAB_FRAME;
               end else begin
                  pte = page_words[tframe * 1024 + int'(va[DIR_IDX_LSB-1:TAB_IDX_LSB])];
                  if (!pte[PRESENT_POS]) begin
                     res.status = ST_TAB_ABSENT;
                  end else begin
                     res.paddr  = {pte[FRAME_BITS-1:0], va[OFFSET_BITS-1:0]};
                     res.status = ST_OK;
                  end
               end
            end
         end
         pending_walks.push_back(res);
      endfunction

      task report_mismatch(string what);
         if (mismatch_count < MAX_PRINTED) $display("[%0t] mismatch: %s", $time, what);
         mismatch_count++;
      endtask

      // Compare one response beat against the oldest queued outcome
      task check_response(logic [31:0] phys, logic [2:0] status);
         walk_result_type want;
         if (pending_walks.size() == 0) begin
            report_mismatch($sformatf("response with none due: phys %h status %0d",
                                      phys, status));
         end else begin
            want = pending_walks.pop_front();
            if (status !== want.status)
               report_mismatch($sformatf("status %0d, want %0d", status, want.status));
            if (phys !== want.paddr)
               report_mismatch($sformatf("paddr %h, want %h", phys, want.paddr));
            if (want.status <= ST_WRITE_DONE) status_count[want.status]++;
         end
      endtask
   endclass

   logic        clock = 1'b0;
   logic        reset;
   logic        csr_wr_en;
   logic [19:0] csr_wr_data;

   tlpw_req_if req_ch ();
   tlpw_rsp_if rsp_ch ();

   walk_mirror mirror;

   int send_idle_pct;
   int recv_idle_pct;
   int hold_requests;
   int cycle_count;

   two_level_page_walk #(.FRAME_COUNT(FRAME_COUNT)) uut (
      .clock       (clock),
      .reset       (reset),
      .req_ch      (req_ch),
      .rsp_ch      (rsp_ch),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always begin
      #CLOCK_HALF clock = 1'b1;
      #CLOCK_HALF clock = 1'b0;
   end

   // Stall the response side at random; hold off for a long stretch on request
   initial begin
      int hold_seen;
      int hold_left;
      hold_seen = 0;
      hold_left = 0;
      rsp_ch.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_requests != hold_seen) begin
            hold_seen = hold_requests;
            hold_left = HOLD_OFF_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
         end
      end
   end

   // Check every response beat
   always @(posedge clock) begin
      if (!reset && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1)
         mirror.check_response(rsp_ch.paddr, rsp_ch.status);
   end

   // End the run if it stops making progress
   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("timeout: run exceeded %0d cycles", CYCLE_LIMIT);
      $display("CHECKS FAILED");
      $finish;
   end

   // Offer one request beat after a random gap; return at the accepting edge
   task automatic drive_item(bit op, logic [31:0] va, logic [7:0] wf,
                             logic [9:0] wi, logic [31:0] we);
      @(negedge clock);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(negedge clock);
      end
      req_ch.valid       <= 1'b1;
      req_ch.op          <= op;
      req_ch.vaddr       <= va;
      req_ch.write_frame <= wf;
      req_ch.write_index <= wi;
      req_ch.write_entry <= we;
      do @(posedge clock); while (req_ch.ready !== 1'b1);
      mirror.note_request(op, va, wf, wi, we);
   endtask

   // Unused fields carry random values
   task automatic send_write(logic [7:0] wf, logic [9:0] wi, logic [31:0] we);
      drive_item(OP_WRITE, $urandom, wf, wi, we);
   endtask

   task automatic send_translate(logic [31:0] va);
      drive_item(OP_TRANSLATE, va, 8'($urandom), 10'($urandom), $urandom);
   endtask

   // Drop valid and wait until every walk has answered
   task automatic drain_walks();
      @(negedge clock);
      req_ch.valid <= 1'b0;
      while (mirror.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic program_base(logic [19:0] base);
      drain_walks();
      @(negedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= base;
      @(negedge clock);
      csr_wr_en   <= 1'b0;
      mirror.set_base(base);
   endtask

   // Small pools of indexes and frames, so that writes and walks meet
   function automatic logic [9:0] pick_index();
      case ($urandom_range(0, 9))
         0:       return 10'd0;
         1:       return 10'd1023;
         2:       return 10'd512;
         3:       return 10'($urandom);
         default: return 10'($urandom_range(0, 3));
      endcase
   endfunction

   function automatic logic [7:0] pick_frame();
      case ($urandom_range(0, 9))
         0:       return 8'd0;
         1:       return 8'd255;
         2:       return 8'd254;
         3:       return 8'($urandom);
         default: return 8'($urandom_range(1, 4));
      endcase
   endfunction

   // Build an entry with random attributes, mostly present
   function automatic logic [31:0] make_entry(bit near_frame);
      logic [11:0] attrs;
      logic [19:0] frame;
      attrs    = 12'($urandom);
      attrs[0] = ($urandom_range(0, 9) != 0);
      if (near_frame && $urandom_range(0, 99) < 85) frame = 20'(pick_frame());
      else frame = 20'($urandom);
      return {attrs, frame};
   endfunction

   // One random beat: mostly walk set-up and walks, some noise
   task automatic random_item(logic [19:0] base);
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 25) begin
         if (int'(base) < FRAME_COUNT) send_write(base[7:0], pick_index(), make_entry(1'b1));
         else send_write(pick_frame(), pick_index(), make_entry(1'b1));
      end else if (pick < 50) begin
         send_write(pick_frame(), pick_index(), make_entry(1'b0));
      end else if (pick < 90) begin
         send_translate({pick_index(), pick_index(), 12'($urandom)});
      end else begin
         drive_item(1'($urandom), $urandom, 8'($urandom), 10'($urandom), $urandom);
      end
   endtask

   initial begin
      logic [19:0] base_plan [PHASE_COUNT];
      int          phase_items [PHASE_COUNT];
      mirror        = new();
      send_idle_pct = 0;
      recv_idle_pct = 0;
      hold_requests = 0;
      reset         = 1'b1;
      csr_wr_en     = 1'b0;
      csr_wr_data   = '0;
      req_ch.valid       = 1'b0;
      req_ch.op          = OP_WRITE;
      req_ch.vaddr       = '0;
      req_ch.write_frame = '0;
      req_ch.write_index = '0;
      req_ch.write_entry = '0;
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed walks with the store cleared and the directory at frame 0
      send_idle_pct = 30;
      recv_idle_pct = 54;
      program_base(20'd0);
      send_translate(32'h0000_0000);
      send_write(8'd0, 10'd0, ENTRY_PRESENT | 32'd1);
      send_translate(32'h0000_0ABC);
      send_write(8'd1, 10'd0, 32'hFFFF_FFFF);
      send_translate(32'h0000_0ABC);
      send_write(8'd0, 10'd1023, ENTRY_PRESENT | 32'd256);
      send_translate(32'hFFC0_0FFF);
      send_write(8'd0, 10'd1023, ENTRY_PRESENT | 32'd255);
      send_write(8'd255, 10'd1023, 32'hFFFF_FFFF);
      send_translate(32'hFFFF_FFFF);
      send_write(8'd0, 10'd2, 32'hFFEF_FFFF);
      send_translate(32'h0080_0000);
      send_write(8'd1, 10'd1, 32'hFFEF_FFFF);
      send_translate(32'h0000_1000);
      send_write(8'd255, 10'd0, ENTRY_PRESENT);
      send_write(8'd0, 10'd1023, ENTRY_PRESENT | 32'h000F_FFFF);
      send_translate(32'hFFC0_0000);
      // Directory frame beyond the store, then at the top frame
      program_base(20'd256);
      send_translate(32'h0000_0000);
      send_write(8'd3, 10'd5, $urandom);
      program_base(20'hFFFFF);
      send_translate(32'hFFFF_FFFF);
      program_base(20'd255);
      send_translate(32'h0000_0123);

      // Random phases over several directory settings and idle regimes
      base_plan   = '{20'd0, 20'd255, 20'hFFFFF, 20'($urandom_range(1, 254)),
                      20'd256, 20'($urandom_range(1, 254))};
      phase_items = '{150, 150, 60, 150, 60, 150};
      for (int p = 0; p < PHASE_COUNT; p++) begin
         program_base(base_plan[p]);
         if (p < 2) begin
            send_idle_pct = 30;
            recv_idle_pct = 54;
         end else if (p < 4) begin
            send_idle_pct = 54;
            recv_idle_pct = 30;
         end else begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         // Hold off the response side while requests keep coming
         if (p == 1 || p == 4) hold_requests++;
         for (int i = 0; i < phase_items[p]; i++) random_item(base_plan[p]);
      end

      drain_walks();
      $display("run: %0d translations and %0d writes over %0d directory settings",
               mirror.translations, mirror.writes, mirror.base_settings);
      $display("run: ok %0d, bad dir %0d, dir absent %0d, bad tab %0d, tab absent %0d",
               mirror.status_count[ST_OK], mirror.status_count[ST_BAD_DIR_FRAME],
               mirror.status_count[ST_DIR_ABSENT], mirror.status_count[ST_BAD_TAB_FRAME],
               mirror.status_count[ST_TAB_ABSENT]);
      if (mirror.mismatch_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
